FILE: rtl/rpia_pkg.sv
// Shared constants, types and codes of the rotating packet identifier allocator.
package rpia_pkg;

    localparam int ID_BITS     = 16;
    localparam int KIND_BITS   = 3;
    localparam int TARGET_BITS = 16;
    localparam int OFF_BITS    = 5;
    localparam int WORD_BITS   = 1 << OFF_BITS;
    localparam int ADDR_BITS   = ID_BITS - OFF_BITS;
    localparam int WORDS       = 1 << ADDR_BITS;
    localparam int CNT_BITS    = ADDR_BITS + 1;

    localparam logic [KIND_BITS-1:0] KIND_ALLOC   = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_RELEASE = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_MARK    = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_UNMARK  = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_CLEAR   = 3'd4;

    typedef logic [ID_BITS-1:0]   id_t;
    typedef logic [ADDR_BITS-1:0] waddr_t;
    typedef logic [WORD_BITS-1:0] bits_t;

    typedef struct packed {
        bits_t held;
        bits_t used;
    } map_word_t;

    typedef struct packed {
        logic      rd_en;
        waddr_t    rd_addr;
        logic      wr_en;
        waddr_t    wr_addr;
        map_word_t wr_data;
    } ram_req_t;

    typedef struct packed {
        logic [TARGET_BITS-1:0] granted_id;
        logic                   granted;
        logic                   exhausted;
    } rpia_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RMW,
        ST_CLEAR,
        ST_REPLY
    } state_t;

endpackage

FILE: rtl/rpia_map_ram.sv
// Bitmap word store: one write and one registered read per cycle.
module rpia_map_ram
    import rpia_pkg::*;
(
    input  logic      aclk,
    input  ram_req_t  req,
    output map_word_t rd_data
);

    map_word_t mem [WORDS];
    map_word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/rpia_ctrl.sv
// Request sequencer: word-wide next-fit search, read-modify-write and clearing sweep.
module rpia_ctrl
    import rpia_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [KIND_BITS-1:0]   s_kind,
    input  logic [TARGET_BITS-1:0] s_target_id,
    output logic                   res_valid,
    input  logic                   res_ready,
    output rpia_result_t           res,
    output ram_req_t               ram_req,
    input  map_word_t              rd_data
);

    localparam id_t ID_ONE = ID_BITS'(1);

    function automatic id_t step_ptr(input id_t p);
        id_t n;
        n = p + ID_ONE;
        return (n == '0) ? ID_ONE : n;
    endfunction

    function automatic logic [OFF_BITS-1:0] first_set(input bits_t v);
        logic [OFF_BITS-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = OFF_BITS'(i);
            end
        end
        return idx;
    endfunction

    state_t                 state_reg, state_next;
    id_t                    ptr_reg, ptr_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                   report_reg, report_next;
    logic [KIND_BITS-1:0]   kind_reg, kind_next;
    logic [TARGET_BITS-1:0] target_reg, target_next;
    waddr_t                 addr_reg, addr_next;
    rpia_result_t           res_reg, res_next;

    logic                accept;
    logic                in_range;
    logic                scan_first, scan_last, found;
    bits_t               ge_mask, scan_mask, free_bits, hit_bit, rmw_bit;
    logic [OFF_BITS-1:0] hit_idx;
    id_t                 cand;
    map_word_t           rmw_word;

    assign accept   = s_valid && s_ready;
    assign in_range = (s_target_id >> ID_BITS) == '0;

    // scan of the word that was read last cycle
    assign scan_first = cnt_reg == '0;
    assign scan_last  = cnt_reg == CNT_BITS'(WORDS);
    assign ge_mask    = {WORD_BITS{1'b1}} << ptr_reg[OFF_BITS-1:0];

    always_comb begin
        if (scan_first) begin
            scan_mask = ge_mask;
        end else if (scan_last) begin
            scan_mask = ~ge_mask;
        end else begin
            scan_mask = {WORD_BITS{1'b1}};
        end
        if (addr_reg == '0) begin
            scan_mask[0] = 1'b0;   // identifier zero is never handed out
        end
    end

    assign free_bits = ~(rd_data.used | rd_data.held) & scan_mask;
    assign found     = |free_bits;
    assign hit_idx   = first_set(free_bits);
    assign hit_bit   = bits_t'(1) << hit_idx;
    assign cand      = {addr_reg, hit_idx};

    assign rmw_bit = bits_t'(1) << target_reg[OFF_BITS-1:0];

    always_comb begin
        rmw_word = rd_data;
        case (kind_reg)
            KIND_RELEASE: rmw_word.used = rd_data.used & ~rmw_bit;
            KIND_MARK:    rmw_word.held = rd_data.held | rmw_bit;
            KIND_UNMARK:  rmw_word.held = rd_data.held & ~rmw_bit;
            default:      rmw_word = rd_data;
        endcase
    end

    // next state and register updates
    always_comb begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        cnt_next    = cnt_reg;
        report_next = report_reg;
        kind_next   = kind_reg;
        target_next = target_reg;
        addr_next   = addr_reg;
        res_next    = res_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_next   = s_kind;
                    target_next = s_target_id;
                    res_next.granted_id = s_target_id;
                    res_next.granted    = 1'b0;
                    res_next.exhausted  = 1'b0;
                    cnt_next = '0;
                    case (s_kind)
                        KIND_ALLOC: begin
                            addr_next  = ptr_reg[ID_BITS-1:OFF_BITS];
                            state_next = ST_SCAN;
                        end
                        KIND_RELEASE, KIND_MARK, KIND_UNMARK: begin
                            addr_next  = s_target_id[ID_BITS-1:OFF_BITS];
                            state_next = in_range ? ST_RMW : ST_REPLY;
                        end
                        KIND_CLEAR: begin
                            report_next = 1'b1;
                            state_next  = ST_CLEAR;
                        end
                        default: state_next = ST_REPLY;
                    endcase
                end
            end
            ST_SCAN: begin
                if (found) begin
                    res_next.granted_id = TARGET_BITS'(cand);
                    res_next.granted    = 1'b1;
                    ptr_next   = step_ptr(cand);
                    state_next = ST_REPLY;
                end else if (scan_last) begin
                    res_next.granted_id = TARGET_BITS'(ptr_reg);
                    res_next.exhausted  = 1'b1;
                    ptr_next   = step_ptr(ptr_reg);
                    state_next = ST_REPLY;
                end else begin
                    addr_next = addr_reg + waddr_t'(1);
                    cnt_next  = cnt_reg + CNT_BITS'(1);
                end
            end
            ST_RMW: begin
                state_next = ST_REPLY;
            end
            ST_CLEAR: begin
                if (cnt_reg == CNT_BITS'(WORDS - 1)) begin
                    ptr_next    = ID_ONE;
                    report_next = 1'b0;
                    state_next  = report_reg ? ST_REPLY : ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + CNT_BITS'(1);
                end
            end
            ST_REPLY: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and memory port
    always_comb begin
        s_ready         = 1'b0;
        res_valid       = 1'b0;
        ram_req.rd_en   = 1'b0;
        ram_req.rd_addr = addr_reg;
        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = addr_reg;
        ram_req.wr_data = rmw_word;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_kind == KIND_ALLOC) begin
                    ram_req.rd_en   = s_valid;
                    ram_req.rd_addr = ptr_reg[ID_BITS-1:OFF_BITS];
                end else begin
                    ram_req.rd_en   = s_valid && in_range;
                    ram_req.rd_addr = s_target_id[ID_BITS-1:OFF_BITS];
                end
            end
            ST_SCAN: begin
                if (found) begin
                    ram_req.wr_en        = 1'b1;
                    ram_req.wr_data.used = rd_data.used | hit_bit;
                    ram_req.wr_data.held = rd_data.held;
                end else if (!scan_last) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = addr_reg + waddr_t'(1);
                end
            end
            ST_RMW: begin
                ram_req.wr_en = 1'b1;
            end
            ST_CLEAR: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = cnt_reg[ADDR_BITS-1:0];
                ram_req.wr_data = '0;
            end
            ST_REPLY: begin
                res_valid = 1'b1;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            ptr_reg    <= ID_ONE;
            cnt_reg    <= '0;
            report_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            cnt_reg    <= cnt_next;
            report_reg <= report_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        target_reg <= target_next;
        addr_reg   <= addr_next;
        res_reg    <= res_next;
    end

endmodule

FILE: rtl/rotating_packet_id_allocator_core.sv
// Top level of the rotating packet identifier allocator: sequencer, bitmap store, result register.
//
// Usage:
//   Requests arrive on the s_ channel (s_kind, s_target_id) under valid/ready;
//   every request gives exactly one result transfer on the m_ channel
//   (m_granted_id, m_granted, m_exhausted), in request order.
//   Kinds: allocate, release, mark QoS2 held, unmark QoS2 held, clear all.
// Timing:
//   One request is worked on at a time. Release, mark and unmark read the
//   target's bitmap word and write it back; out-of-range and unknown
//   requests skip the memory. Allocate reads one 32-identifier bitmap word
//   per cycle, starting at the word of the next-candidate pointer and
//   stopping at the first word with a free identifier; when every
//   identifier is taken it reads 2^ID_BITS/32 + 1 words, the pointer's
//   word again last. Clear all sweeps the store one word a cycle, over
//   all 2^ID_BITS/32 words (2048 at 16 bits).
// Reset:
//   aresetn (synchronous, low) starts a clearing sweep over all 2^ID_BITS/32
//   words (2048 at 16 bits); s_ready stays low until it is done.
// Stalls:
//   A result waits in the output register while m_ready is low; the next
//   request is still taken and worked on, and its result is held back until
//   the output register frees.
module rotating_packet_id_allocator_core
    import rpia_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [KIND_BITS-1:0]   s_kind,
    input  logic [TARGET_BITS-1:0] s_target_id,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [TARGET_BITS-1:0] m_granted_id,
    output logic                   m_granted,
    output logic                   m_exhausted
);

    ram_req_t     ram_req;
    map_word_t    rd_data;
    rpia_result_t res;
    logic         res_valid;
    logic         res_ready;

    logic         m_valid_reg, m_valid_next;
    rpia_result_t m_res_reg;

    rpia_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_target_id (s_target_id),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_req     (ram_req),
        .rd_data     (rd_data)
    );

    rpia_map_ram u_map_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    // Output register: loads when empty or when its result leaves this cycle.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_granted_id = m_res_reg.granted_id;
    assign m_granted    = m_res_reg.granted;
    assign m_exhausted  = m_res_reg.exhausted;

endmodule
